>>> sv/ypd_pkg.sv
// Shared types and constants for the YIN pitch detector.
// No dependencies; imported by all ypd_* modules and the top level.
`default_nettype none
package ypd_pkg;

  localparam int SR_W      = 18;
  localparam int THR_W     = 16;
  localparam int HW_W      = 10;
  localparam int CFG_AW    = 2;
  localparam int NORM_W    = 24;
  localparam int LAG_W     = 18;
  localparam int PITCH_W   = 26;
  localparam int PROB_W    = 17;
  localparam int QW        = 34;
  localparam int STEP_W    = 6;
  localparam int LS_W      = 36;
  localparam int OUT_DW    = 64;

  localparam logic [NORM_W-1:0]  NORM_SAT  = 24'hFFFFFF;
  localparam logic [NORM_W-1:0]  NORM_ONE  = 24'h010000;
  localparam logic [LAG_W-1:0]   LAG_MAX   = 18'h3FFFF;
  localparam logic [PITCH_W-1:0] PITCH_MAX = 26'h3FFFFFF;
  localparam logic [STEP_W-1:0]  NORM_STEPS = 6'd24;
  localparam logic [STEP_W-1:0]  FULL_STEPS = 6'd34;

  typedef enum logic [CFG_AW-1:0] {
    REG_SAMPLE_RATE = 2'd0,
    REG_THRESHOLD   = 2'd1,
    REG_HALF_WINDOW = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic smp_wr;
    logic frame_start;
    logic mac_issue;
    logic mul;
    logic norm_load;
    logic norm_upd;
    logic ip_prep;
    logic ip_load;
    logic ip_fin;
    logic pitch_load;
    logic pitch_fin;
    logic res_load;
  } ypd_cmd_t;

  typedef struct packed {
    logic frame_end;
    logic last_i;
    logic pipe_busy;
    logic div_busy;
    logic last_tau;
    logic found;
    logic no_succ;
    logic den_zero;
    logic lag_zero;
    logic out_free;
  } ypd_stat_t;

  function automatic logic [LAG_W-1:0] lag_sat(input logic signed [LS_W-1:0] v);
    logic [LAG_W-1:0] r;
    if (v < 0) r = '0;
    else if (v > $signed({{(LS_W-LAG_W){1'b0}}, LAG_MAX})) r = LAG_MAX;
    else r = v[LAG_W-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/ypd_divider.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on ypd_pkg; instantiated by ypd_datapath.
`default_nettype none
module ypd_divider import ypd_pkg::*; #(
  parameter int DVW = 60
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire logic [DVW-1:0]    rem_init,
  input  wire logic [QW-1:0]     dividend,
  input  wire logic [DVW-1:0]    divisor,
  input  wire logic [STEP_W-1:0] steps,
  output logic                   busy,
  output logic [QW-1:0]          quotient
);

  logic [DVW-1:0]    rem_r;
  logic [QW-1:0]     quo_r;
  logic [DVW-1:0]    div_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic [DVW:0]      trial;
  logic              ge;
  logic [DVW:0]      rem_nxt;

  assign trial   = {rem_r, quo_r[QW-1]};
  assign ge      = trial >= {1'b0, div_r};
  assign rem_nxt = ge ? trial - {1'b0, div_r} : trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      cnt_r  <= steps;
    end else if (busy_r) begin
      cnt_r <= cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= rem_init;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt[DVW-1:0];
      quo_r <= {quo_r[QW-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

>>> sv/ypd_datapath.sv
// Datapath: sample memory, MAC pipeline, normalization, lag search,
// interpolation, pitch and result register. Depends on ypd_pkg, ypd_divider.
`default_nettype none
module ypd_datapath import ypd_pkg::*; #(
  parameter int MAX_HW = 512,
  parameter int SB     = 16,
  localparam int WW    = $clog2(MAX_HW + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ypd_cmd_t         cmd,
  output ypd_stat_t             stat,
  input  wire logic [SB-1:0]    smp,
  input  wire logic [SR_W-1:0]  sample_rate,
  input  wire logic [THR_W-1:0] threshold,
  input  wire logic [WW-1:0]    win,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output logic                  out_pv,
  output logic [PITCH_W-1:0]    out_pitch,
  output logic [LAG_W-1:0]      out_lag,
  output logic [PROB_W-1:0]     out_prob
);

  localparam int AW   = $clog2(2 * MAX_HW);
  localparam int TW   = $clog2(MAX_HW);
  localparam int CW   = $clog2(2 * MAX_HW + 1);
  localparam int SQW  = 2 * SB + 2;
  localparam int ACCW = SQW + TW;
  localparam int SUMW = ACCW + TW;
  localparam int DVW  = SUMW + 8;
  localparam int NUMW = NORM_W + 9;
  localparam int DENW = NORM_W + 4;

  logic [SB-1:0]      smem [2*MAX_HW];
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      cnt_inc;
  logic [TW-1:0]      i_r, tau_r;
  logic [WW-1:0]      win_m1;
  logic [AW-1:0]      addr_b;
  logic [SB-1:0]      rd_a_r, rd_b_r;
  logic               v1_r, v2_r;
  logic signed [SB:0] diff;
  logic signed [2*SB+1:0] sq_full;
  logic [SQW-1:0]     sq_r;
  logic [ACCW-1:0]    acc_r;
  logic [SUMW-1:0]    sum_r, prod_r, prod_full;
  logic               sat_now, sat_r;
  logic [NORM_W-1:0]  nv, prev_r, s0_r, s1_r, s2_r;
  logic               found_r, walk_r, has_s2_r;
  logic [TW-1:0]      cand_r, lag_tau;
  logic signed [NUMW-1:0] num_c, num_r, num_abs;
  logic signed [DENW-1:0] den_c, den_r, den_abs;
  logic [LAG_W-1:0]   lag_r;
  logic [PITCH_W-1:0] pitch_r;
  logic signed [LS_W-1:0] q_s;
  logic               dv_load, dv_busy;
  logic [DVW-1:0]     dv_rem, dv_div;
  logic [QW-1:0]      dv_quo, dv_q;
  logic [STEP_W-1:0]  dv_steps;
  logic               out_valid_r, out_pv_r;
  logic [PITCH_W-1:0] out_pitch_r;
  logic [LAG_W-1:0]   out_lag_r;
  logic [PROB_W-1:0]  out_prob_r;

  assign cnt_inc = count_r + CW'(1);
  assign win_m1  = win - WW'(1);
  assign addr_b  = AW'({1'b0, i_r}) + AW'({1'b0, tau_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.smp_wr) begin
      count_r <= stat.frame_end ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.smp_wr) smem[count_r[AW-1:0]] <= smp;
    if (cmd.mac_issue) begin
      rd_a_r <= smem[AW'({1'b0, i_r})];
      rd_b_r <= smem[addr_b];
    end
  end

  assign diff    = $signed({rd_a_r[SB-1], rd_a_r}) - $signed({rd_b_r[SB-1], rd_b_r});
  assign sq_full = diff * diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.mac_issue;
      v2_r <= v1_r;
    end
  end

  assign prod_full = acc_r * tau_r;
  assign sat_now   = (sum_r == '0) || (DVW'(prod_r) >= {sum_r, 8'b0});
  assign nv        = sat_r ? NORM_SAT : dv_q[NORM_W-1:0];

  always_ff @(posedge clk) begin
    sq_r <= SQW'($unsigned(sq_full));
    if (cmd.frame_start || cmd.norm_upd) begin
      i_r   <= '0;
      acc_r <= '0;
    end else begin
      if (cmd.mac_issue) i_r <= i_r + TW'(1);
      if (v2_r) acc_r <= acc_r + ACCW'(sq_r);
    end
    if (cmd.frame_start) tau_r <= TW'(1);
    else if (cmd.norm_upd) tau_r <= tau_r + TW'(1);
    if (cmd.frame_start) sum_r <= '0;
    else if (cmd.mul) sum_r <= sum_r + SUMW'(acc_r);
    if (cmd.mul) prod_r <= prod_full;
    if (cmd.norm_load) sat_r <= sat_now;
  end

  // first lag under threshold, then follow it down while d' keeps falling
  always_ff @(posedge clk) begin
    if (cmd.frame_start) begin
      found_r  <= 1'b0;
      walk_r   <= 1'b0;
      has_s2_r <= 1'b0;
      prev_r   <= NORM_ONE;
    end else if (cmd.norm_upd) begin
      prev_r <= nv;
      if (!found_r && (tau_r >= TW'(2)) && (nv < NORM_W'(threshold))) begin
        found_r <= 1'b1;
        walk_r  <= 1'b1;
        cand_r  <= tau_r;
        s0_r    <= prev_r;
        s1_r    <= nv;
      end else if (walk_r) begin
        if (nv < s1_r) begin
          cand_r <= tau_r;
          s0_r   <= prev_r;
          s1_r   <= nv;
        end else begin
          walk_r   <= 1'b0;
          s2_r     <= nv;
          has_s2_r <= 1'b1;
        end
      end
    end
  end

  assign num_c   = $signed({1'b0, s2_r, 8'b0}) - $signed({1'b0, s0_r, 8'b0});
  assign den_c   = $signed({2'b0, s1_r, 2'b0}) - $signed({3'b0, s2_r, 1'b0})
                 - $signed({3'b0, s0_r, 1'b0});
  assign num_abs = num_r[NUMW-1] ? -num_r : num_r;
  assign den_abs = den_r[DENW-1] ? -den_r : den_r;
  assign lag_tau = (has_s2_r || (s1_r <= s0_r)) ? cand_r : cand_r - TW'(1);
  assign q_s     = (num_r[NUMW-1] ^ den_r[DENW-1]) ? -$signed({2'b0, dv_q})
                                                   : $signed({2'b0, dv_q});

  always_ff @(posedge clk) begin
    if (cmd.ip_prep) begin
      num_r <= num_c;
      den_r <= den_c;
      lag_r <= lag_sat($signed(LS_W'({lag_tau, 8'b0})));
    end else if (cmd.ip_fin) begin
      lag_r <= lag_sat($signed({{(LS_W-LAG_W){1'b0}}, lag_r}) + q_s);
    end
    if (cmd.pitch_load && (lag_r == '0)) pitch_r <= PITCH_MAX;
    else if (cmd.pitch_fin)
      pitch_r <= (dv_q > QW'(PITCH_MAX)) ? PITCH_MAX : dv_q[PITCH_W-1:0];
  end

  always_comb begin
    dv_load  = 1'b0;
    dv_rem   = '0;
    dv_quo   = '0;
    dv_div   = '0;
    dv_steps = FULL_STEPS;
    if (cmd.norm_load && !sat_now) begin
      dv_load  = 1'b1;
      dv_rem   = DVW'(prod_r);
      dv_div   = {sum_r, 8'b0};
      dv_steps = NORM_STEPS;
    end else if (cmd.ip_load) begin
      dv_load = 1'b1;
      dv_quo  = QW'($unsigned(num_abs));
      dv_div  = DVW'($unsigned(den_abs));
    end else if (cmd.pitch_load && (lag_r != '0)) begin
      dv_load = 1'b1;
      dv_quo  = {sample_rate, 16'b0};
      dv_div  = DVW'(lag_r);
    end
  end

  ypd_divider #(.DVW(DVW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (dv_load),
    .rem_init (dv_rem),
    .dividend (dv_quo),
    .divisor  (dv_div),
    .steps    (dv_steps),
    .busy     (dv_busy),
    .quotient (dv_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_pv_r    <= found_r;
      out_pitch_r <= found_r ? pitch_r : '0;
      out_lag_r   <= found_r ? lag_r : '0;
      out_prob_r  <= found_r ? PROB_W'(NORM_ONE) - PROB_W'(s1_r) : '0;
    end
  end

  assign stat.frame_end = cnt_inc >= CW'({win, 1'b0});
  assign stat.last_i    = i_r == win_m1[TW-1:0];
  assign stat.pipe_busy = v1_r | v2_r;
  assign stat.div_busy  = dv_busy;
  assign stat.last_tau  = tau_r == win_m1[TW-1:0];
  assign stat.found     = found_r;
  assign stat.no_succ   = !has_s2_r;
  assign stat.den_zero  = den_r == '0;
  assign stat.lag_zero  = lag_r == '0;
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_pv    = out_pv_r;
  assign out_pitch = out_pitch_r;
  assign out_lag   = out_lag_r;
  assign out_prob  = out_prob_r;

endmodule
`default_nettype wire

>>> sv/ypd_ctrl.sv
// Frame sequencer: sample capture, per-lag MAC and divide, interpolation, pitch.
// Depends on ypd_pkg; drives ypd_datapath through ypd_cmd_t.
`default_nettype none
module ypd_ctrl import ypd_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire ypd_stat_t stat,
  output ypd_cmd_t       cmd
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_MAC   = 11'b00000000010,
    S_DRAIN = 11'b00000000100,
    S_NCHK  = 11'b00000001000,
    S_NDIV  = 11'b00000010000,
    S_IPREP = 11'b00000100000,
    S_ICHK  = 11'b00001000000,
    S_IDIV  = 11'b00010000000,
    S_PLOAD = 11'b00100000000,
    S_PDIV  = 11'b01000000000,
    S_RES   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.smp_wr = 1'b1;
          if (stat.frame_end) begin
            cmd.frame_start = 1'b1;
            state_nxt       = S_MAC;
          end
        end
      end
      S_MAC: begin
        cmd.mac_issue = 1'b1;
        if (stat.last_i) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          cmd.mul   = 1'b1;
          state_nxt = S_NCHK;
        end
      end
      S_NCHK: begin
        cmd.norm_load = 1'b1;
        state_nxt     = S_NDIV;
      end
      S_NDIV: begin
        if (!stat.div_busy) begin
          cmd.norm_upd = 1'b1;
          state_nxt    = stat.last_tau ? S_IPREP : S_MAC;
        end
      end
      S_IPREP: begin
        cmd.ip_prep = 1'b1;
        if (!stat.found) state_nxt = S_RES;
        else if (stat.no_succ) state_nxt = S_PLOAD;
        else state_nxt = S_ICHK;
      end
      S_ICHK: begin
        if (stat.den_zero) begin
          state_nxt = S_PLOAD;
        end else begin
          cmd.ip_load = 1'b1;
          state_nxt   = S_IDIV;
        end
      end
      S_IDIV: begin
        if (!stat.div_busy) begin
          cmd.ip_fin = 1'b1;
          state_nxt  = S_PLOAD;
        end
      end
      S_PLOAD: begin
        cmd.pitch_load = 1'b1;
        state_nxt      = stat.lag_zero ? S_RES : S_PDIV;
      end
      S_PDIV: begin
        if (!stat.div_busy) begin
          cmd.pitch_fin = 1'b1;
          state_nxt     = S_RES;
        end
      end
      S_RES: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule
`default_nettype wire

>>> sv/yin_pitch_detector_top.sv
// Top level of the YIN pitch detector: config registers, controller, datapath.
// Depends on ypd_pkg, ypd_ctrl, ypd_datapath (ypd_divider).
//
//  Channel  Dir  Ports                                Payload
//  in       in   in_tvalid/in_tready/in_tdata         one signed sample
//  out      out  out_tvalid/out_tready/out_tdata/user  pitch, lag, probability, valid
//  cfg      in   cfg_we/cfg_addr/cfg_wdata            sample_rate, threshold, half_window
//
// Samples transfer at one per cycle while the frame is filling (2W samples).
// After the last sample, each lag 1..W-1 runs a MAC over W sample pairs
// through the dual-read sample memory, then a 24-step normalize divide
// unless d' saturates. Interpolation and pitch use up to two 34-step divides.
// Input is stalled during that work; a finished result waits in the output
// register while the next frame fills. Reset is synchronous and needs no sweep.
`default_nettype none
module yin_pitch_detector_top import ypd_pkg::*; #(
  parameter int MAX_HALF_WINDOW = 512,
  parameter int SAMPLE_BITS     = 16,
  localparam int IN_DW = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_DW-1:0]  in_tdata,   // sample
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_DW-1:0]      out_tdata,  // pitch_hz, lag_estimate, probability
  output logic [0:0]             out_tuser,  // pitch_valid
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [SR_W-1:0]   cfg_wdata
);

  localparam int WW = $clog2(MAX_HALF_WINDOW + 1);

  logic [SR_W-1:0]    sr_r;
  logic [THR_W-1:0]   thr_r;
  logic [HW_W-1:0]    hw_r;
  logic [WW-1:0]      w_eff;
  ypd_cmd_t           cmd;
  ypd_stat_t          stat;
  logic               out_pv;
  logic [PITCH_W-1:0] out_pitch;
  logic [LAG_W-1:0]   out_lag;
  logic [PROB_W-1:0]  out_prob;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_r  <= SR_W'(44100);
      thr_r <= THR_W'(52429);
      hw_r  <= HW_W'(512);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SAMPLE_RATE: sr_r  <= cfg_wdata;
        REG_THRESHOLD:   thr_r <= cfg_wdata[THR_W-1:0];
        REG_HALF_WINDOW: hw_r  <= cfg_wdata[HW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (hw_r < HW_W'(4)) w_eff = WW'(4);
    else if (32'(hw_r) > MAX_HALF_WINDOW) w_eff = WW'(MAX_HALF_WINDOW);
    else w_eff = WW'(hw_r);
  end

  ypd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ypd_datapath #(
    .MAX_HW (MAX_HALF_WINDOW),
    .SB     (SAMPLE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .smp         (in_tdata[SAMPLE_BITS-1:0]),
    .sample_rate (sr_r),
    .threshold   (thr_r),
    .win         (w_eff),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_pv      (out_pv),
    .out_pitch   (out_pitch),
    .out_lag     (out_lag),
    .out_prob    (out_prob)
  );

  assign out_tdata = {{(OUT_DW-PITCH_W-LAG_W-PROB_W){1'b0}}, out_prob, out_lag, out_pitch};
  assign out_tuser = out_pv;

  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !stat.div_busy) else $error("divider busy while taking samples");

  a_res_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> stat.out_free) else $error("result overwrote pending transfer");

  a_div_once: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.norm_load, cmd.ip_load, cmd.pitch_load}))
    else $error("divider loaded twice");

  a_no_lag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == '0))
    else $error("fields not cleared with no lag found");

endmodule
`default_nettype wire

>>> tb/sv/tb_yin_pitch_detector_top.sv
// Self-checking testbench for yin_pitch_detector_top: streams sample frames,
// predicts each frame's pitch result in SV and checks the out stream.
// Depends on ypd_pkg and the yin_pitch_detector_top RTL.
`default_nettype none
module tb_yin_pitch_detector_top;
  import ypd_pkg::*;

  localparam int WD_LIMIT = 1500000;

  typedef struct packed {
    logic                found;
    logic [PITCH_W-1:0]  hz;
    logic [LAG_W-1:0]    lag;
    logic [PROB_W-1:0]   prob;
  } pitch_res_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [15:0]       in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;
  logic [0:0]        out_tuser;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [SR_W-1:0]   cfg_wdata = '0;

  logic [15:0]  sample_q[$];
  pitch_res_t   pitch_q[$];
  int           idle_pct = 10;
  int           mismatches = 0;
  int           quiet_cycles = 0;
  int           sent = 0;

  // predictor state
  logic [SR_W-1:0]     rate_m;
  logic [THR_W-1:0]    thr_m;
  logic [HW_W-1:0]     hw_m;
  logic signed [15:0]  frame_buf[1024];
  int unsigned         fill_cnt;

  yin_pitch_detector_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int eff_window();
    int w;
    w = hw_m;
    if (w < 4) w = 4;
    if (w > 512) w = 512;
    return w;
  endfunction

  // floor(num * 2^16 / den), saturating at integer part >= 256
  function automatic logic [NORM_W-1:0] norm_q816(longint unsigned num,
                                                  longint unsigned den);
    longint unsigned q, r;
    q = num / den;
    r = num % den;
    if (q >= 256) return NORM_SAT;
    for (int k = 0; k < 16; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
    end
    return q[NORM_W-1:0];
  endfunction

  function automatic pitch_res_t yin_frame(int w);
    longint unsigned diff_sum[512];
    longint          dn[512];
    longint unsigned run_sum, pq;
    longint          d, s0, s1, s2, den, lag;
    int              tau;
    bit              found;
    pitch_res_t      r;
    run_sum = 0;
    found = 0;
    r = '0;
    for (int t = 0; t < w; t++) begin
      diff_sum[t] = 0;
      for (int i = 0; i < w; i++) begin
        d = longint'(frame_buf[i]) - longint'(frame_buf[i + t]);
        diff_sum[t] += longint'(d * d);
      end
    end
    dn[0] = NORM_ONE;
    for (int t = 1; t < w; t++) begin
      run_sum += diff_sum[t];
      if (run_sum == 0) dn[t] = NORM_SAT;
      else dn[t] = norm_q816(diff_sum[t] * longint'(t), run_sum);
    end
    tau = 2;
    while (tau < w && !found) begin
      if (dn[tau] < thr_m) begin
        while (tau + 1 < w && dn[tau + 1] < dn[tau]) tau++;
        found = 1;
      end else begin
        tau++;
      end
    end
    if (!found) return r;
    if (tau + 1 >= w) begin
      lag = (dn[tau] <= dn[tau - 1]) ? tau * 256 : (tau - 1) * 256;
    end else begin
      s0 = dn[tau - 1];
      s1 = dn[tau];
      s2 = dn[tau + 1];
      den = 2 * (2 * s1 - s2 - s0);
      lag = tau * 256;
      if (den != 0) lag += ((s2 - s0) * 256) / den;
    end
    if (lag < 0) lag = 0;
    if (lag > LAG_MAX) lag = LAG_MAX;
    if (lag == 0) begin
      pq = PITCH_MAX;
    end else begin
      pq = (longint'(rate_m) << 16) / lag;
      if (pq > PITCH_MAX) pq = PITCH_MAX;
    end
    r.found = 1'b1;
    r.hz = pq[PITCH_W-1:0];
    r.lag = lag[LAG_W-1:0];
    r.prob = PROB_W'(NORM_ONE - dn[tau]);
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (sample_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata <= sample_q.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= idle_pct);
  end

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    pitch_res_t exp_r, got;
    int w;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        w = eff_window();
        frame_buf[fill_cnt] = in_tdata;
        fill_cnt++;
        if (fill_cnt >= 2 * w) begin
          fill_cnt = 0;
          pitch_q.push_back(yin_frame(w));
        end
      end
      if (out_tvalid && out_tready) begin
        got.found = out_tuser[0];
        got.hz = out_tdata[PITCH_W-1:0];
        got.lag = out_tdata[PITCH_W +: LAG_W];
        got.prob = out_tdata[PITCH_W+LAG_W +: PROB_W];
        if (pitch_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer: %p", got);
        end else begin
          exp_r = pitch_q.pop_front();
          if (got !== exp_r || out_tdata[OUT_DW-1:PITCH_W+LAG_W+PROB_W] !== '0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: exp %p got %p", exp_r, got);
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WD_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic set_reg(cfg_reg_t idx, logic [SR_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SAMPLE_RATE: rate_m = val;
      REG_THRESHOLD:   thr_m = val[THR_W-1:0];
      default:         hw_m = val[HW_W-1:0];
    endcase
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || in_tvalid || pitch_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic push_sample(logic [15:0] s);
    sample_q.push_back(s);
    sent++;
  endtask

  task automatic push_frame(int n, int mode);
    logic [15:0] pat[64];
    int p, amp;
    p = $urandom_range(2, (n / 2 > 63) ? 63 : n / 2);
    amp = $urandom_range(1, 32767);
    for (int k = 0; k < 64; k++) pat[k] = $urandom_range(0, 2 * amp) - amp;
    for (int k = 0; k < n; k++) begin
      case (mode)
        0: push_sample($urandom);
        1: push_sample(pat[k % p]);
        2: push_sample(pat[k % p] + $urandom_range(0, 63) - 32);
        default: push_sample(pat[0]);
      endcase
    end
  endtask

  initial begin
    int w;
    rate_m = 44100;
    thr_m = 52429;
    hw_m = 512;
    fill_cnt = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: smallest window, extreme samples and settings
    set_reg(REG_HALF_WINDOW, 0);
    set_reg(REG_THRESHOLD, 65535);
    set_reg(REG_SAMPLE_RATE, 1);
    for (int k = 0; k < 8; k++) push_sample(k[0] ? 16'h7FFF : 16'h8000);
    for (int k = 0; k < 8; k++) push_sample(16'h0000);
    for (int k = 0; k < 8; k++) push_sample(16'hFFFF);
    drain();
    set_reg(REG_SAMPLE_RATE, 192000);
    set_reg(REG_THRESHOLD, 0);
    push_frame(8, 0);
    push_frame(8, 1);
    drain();
    // window shrunk while a frame is partly filled
    set_reg(REG_THRESHOLD, 40000);
    set_reg(REG_HALF_WINDOW, 8);
    push_frame(10, 1);
    drain();
    set_reg(REG_HALF_WINDOW, 4);
    push_sample(16'h1234);
    drain();
    // largest window via an out-of-range setting, streamed with no idling
    set_reg(REG_HALF_WINDOW, 1023);
    set_reg(REG_SAMPLE_RATE, 44100);
    idle_pct = 0;
    push_frame(1024, 2);
    drain();
    idle_pct = 10;

    while (sent < 1550) begin
      set_reg(REG_SAMPLE_RATE, $urandom_range(0, 3) == 0 ? 192000 : $urandom_range(1, 192000));
      set_reg(REG_THRESHOLD, $urandom_range(0, 3) == 0 ? 65535 : $urandom_range(0, 65535));
      set_reg(REG_HALF_WINDOW, $urandom_range(0, 5) == 0 ? $urandom_range(0, 4)
                                                      : $urandom_range(4, 24));
      idle_pct = (sent > 1200 && sent < 1400) ? 0 : 10;
      w = eff_window();
      repeat ($urandom_range(3, 6)) push_frame(2 * w, $urandom_range(0, 5) % 4);
      drain();
    end

    drain();
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
